>>> design/adaptive_cascade_range_smoother_assert.svh
// Assertion macros shared by the range smoother modules.
`ifndef ADAPTIVE_CASCADE_RANGE_SMOOTHER_ASSERT_SVH
`define ADAPTIVE_CASCADE_RANGE_SMOOTHER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define ACRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acrs assertion failed");
// next-cycle implication
`define ACRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acrs assertion failed");
`else
`define ACRS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ACRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/acrs_pkg.sv
// Package: widths, types, constants and helpers of the range smoother.
`default_nettype none
package acrs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 16;
  localparam int FRAC_BITS   = 6;
  localparam int OUT_W       = 24;
  localparam int TAPS        = 4;
  localparam int NUM_CELLS   = 4;
  localparam int WIN_W       = SAMPLE_BITS + FRAC_BITS;
  localparam int SUM_W       = WIN_W + 2;
  localparam int CMP_W       = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int ORD_W       = 3;
  localparam int VRUN_W      = 5;
  localparam int IRUN_W      = 3;
  localparam int CFG_IDX_W   = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_W-1:0]       cfg_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [WIN_W-1:0]       win_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [OUT_W-1:0]       res_t;
  typedef logic [ORD_W-1:0]       ord_t;
  typedef logic [VRUN_W-1:0]      vrun_t;
  typedef logic [IRUN_W-1:0]      irun_t;

  // Register reset values
  localparam cfg_t PRESENCE_RST  = cfg_t'(200);
  localparam cfg_t JUMP_RST      = cfg_t'(3000);
  localparam cfg_t VALID_TH_RST  = cfg_t'(200);
  localparam cfg_t EDGE_TH_RST   = cfg_t'(50);
  localparam ord_t ORDER_RST     = ord_t'(0);
  localparam ord_t ORDER_MAX     = ord_t'(4);
  localparam ord_t ORDER_DEFAULT = ord_t'(3);
  localparam vrun_t VRUN_MAX     = '1;
  localparam irun_t IRUN_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESENCE   = 3'd0,
    REG_JUMP       = 3'd1,
    REG_VALID_TH   = 3'd2,
    REG_EDGE_TH    = 3'd3,
    REG_INIT_ORDER = 3'd4
  } cfg_reg_e;

  // One request as it moves down the cell row
  typedef struct packed {
    logic vld;
    logic shift;
    logic valid;
    logic edge_hit;
    ord_t used;
    ord_t hops;     // cells left until the selected window sum is taken
    win_t data;     // value entering the next cell's window
    res_t result;
  } stage_t;

  function automatic cmp_t abs_diff(cmp_t a, cmp_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

>>> design/acrs_if.sv
// Request and result channel interfaces of the range smoother.
`default_nettype none
interface acrs_in_if;
  logic                     valid;
  logic                     ready;
  logic [acrs_pkg::SAMPLE_BITS-1:0] range_sample;

  modport source (output valid, output range_sample, input ready);
  modport sink   (input valid, input range_sample, output ready);
endinterface

interface acrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [acrs_pkg::OUT_W-1:0] smoothed_range;
  logic                       sample_valid;
  logic                       edge_found;
  logic [acrs_pkg::ORD_W-1:0] order_used;

  modport source (output valid, output smoothed_range, output sample_valid,
                  output edge_found, output order_used, input ready);
  modport sink   (input valid, input smoothed_range, input sample_valid,
                  input edge_found, input order_used, output ready);
endinterface
`default_nettype wire

>>> design/adaptive_cascade_range_smoother.sv
// Top level: control front end followed by a row of four smoothing cells.
// A request's result is registered in the front register and then in one register
// per cell before it appears at the output.
// Throughput: one request per cycle; the row only stalls while the result is not taken.
// Reset (async, active low) clears windows, run counters and order to zero and sets thresholds to defaults.
`default_nettype none
module adaptive_cascade_range_smoother (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [acrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [acrs_pkg::CFG_W-1:0]     cfg_data_i,
  acrs_in_if.sink                             sample_i,
  acrs_out_if.source                          result_o
);

  `include "adaptive_cascade_range_smoother_assert.svh"

  acrs_pkg::stage_t stages [acrs_pkg::NUM_CELLS+1];
  acrs_pkg::stage_t res;
  logic adv;

  // Whole row moves when the output register is empty or being drained
  assign res = stages[acrs_pkg::NUM_CELLS];
  assign adv = !res.vld || result_o.ready;
  assign sample_i.ready = adv;

  acrs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (sample_i.valid),
    .req_sample_i (sample_i.range_sample),
    .adv_i        (adv),
    .stage_o      (stages[0])
  );

  for (genvar g = 0; g < acrs_pkg::NUM_CELLS; g++) begin : g_cell
    acrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (stages[g]),
      .stage_o (stages[g+1])
    );
  end

  assign result_o.valid          = res.vld;
  assign result_o.smoothed_range = res.result;
  assign result_o.sample_valid   = res.valid;
  assign result_o.edge_found     = res.edge_hit;
  assign result_o.order_used     = res.used;

  `ACRS_ASSERT_NOW(a_hops_spent, clk_i, rst_ni, res.vld, res.hops == '0)
  `ACRS_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, res.vld && !res.valid, res.result == '0)

endmodule
`default_nettype wire

>>> design/acrs_ctrl.sv
// Front control: config registers, validity and edge checks, order adaptation.
`default_nettype none
module acrs_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [acrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [acrs_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           req_valid_i,
  input  wire acrs_pkg::sample_t              req_sample_i,
  input  wire logic                           adv_i,
  output acrs_pkg::stage_t                    stage_o
);

  `include "adaptive_cascade_range_smoother_assert.svh"

  acrs_pkg::cfg_t    presence_q, jump_q, valid_th_q, edge_th_q;
  acrs_pkg::sample_t prev_q, prev_d;
  acrs_pkg::sample_t lastq_q, lastq_d;
  acrs_pkg::vrun_t   vrun_q, vrun_d;
  acrs_pkg::irun_t   irun_q, irun_d;
  acrs_pkg::ord_t    order_q, order_d;
  acrs_pkg::stage_t  stage_q, stage_d;

  logic accept;
  logic valid, edge_hit;
  acrs_pkg::cmp_t x_c, prev_c, lastq_c;

  assign accept  = req_valid_i && adv_i;
  assign x_c     = acrs_pkg::cmp_t'(req_sample_i);
  assign prev_c  = acrs_pkg::cmp_t'(prev_q);
  assign lastq_c = acrs_pkg::cmp_t'(lastq_q);

  // Validity and edge checks
  always_comb begin
    logic gt_p;
    gt_p  = x_c > acrs_pkg::cmp_t'(presence_q);
    valid = gt_p;
    if (prev_c > acrs_pkg::cmp_t'(presence_q)) begin
      valid = gt_p &&
              (acrs_pkg::abs_diff(x_c, prev_c) <= acrs_pkg::cmp_t'(jump_q));
    end
    edge_hit = 1'b0;
    lastq_d  = lastq_q;
    prev_d   = req_sample_i;
    if (x_c > acrs_pkg::cmp_t'(valid_th_q)) begin
      edge_hit = (lastq_q != '0) &&
                 (acrs_pkg::abs_diff(x_c, lastq_c) > acrs_pkg::cmp_t'(edge_th_q));
      lastq_d  = req_sample_i;
    end
  end

  // Run counters and order adaptation
  always_comb begin
    vrun_d  = vrun_q;
    irun_d  = irun_q;
    if (valid) begin
      irun_d = '0;
      if (edge_hit) begin
        vrun_d = '0;
      end else if (vrun_q != acrs_pkg::VRUN_MAX) begin
        vrun_d = vrun_q + 1'b1;
      end
    end else begin
      vrun_d = '0;
      if (irun_q != acrs_pkg::IRUN_MAX) irun_d = irun_q + 1'b1;
    end

    order_d = order_q;
    if (edge_hit || irun_d == 3'd3) begin
      order_d = '0;
    end else if (irun_d == 3'd2) begin
      if (order_q >= 3'd1) order_d = 3'd1;
    end else if (irun_d == 3'd1) begin
      if (order_q >= 3'd2) order_d = 3'd2;
    end else if (vrun_d inside {5'd4, 5'd8, 5'd12, 5'd16}) begin
      if (order_q >= acrs_pkg::ORDER_MAX) order_d = acrs_pkg::ORDER_MAX;
      else                                order_d = order_q + 1'b1;
    end
  end

  // Request handed to the first cell
  always_comb begin
    stage_d          = '0;
    stage_d.vld      = req_valid_i;
    stage_d.shift    = valid && !edge_hit;
    stage_d.valid    = valid;
    stage_d.edge_hit = edge_hit;
    stage_d.used     = order_q;
    stage_d.hops     = valid ? order_q : '0;
    stage_d.data     = acrs_pkg::win_t'({req_sample_i, {acrs_pkg::FRAC_BITS{1'b0}}});
    stage_d.result   = valid ? acrs_pkg::res_t'({req_sample_i, 8'h00}) : '0;
  end

  // Config and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presence_q <= acrs_pkg::PRESENCE_RST;
      jump_q     <= acrs_pkg::JUMP_RST;
      valid_th_q <= acrs_pkg::VALID_TH_RST;
      edge_th_q  <= acrs_pkg::EDGE_TH_RST;
      prev_q     <= '0;
      lastq_q    <= '0;
      vrun_q     <= '0;
      irun_q     <= '0;
      order_q    <= acrs_pkg::ORDER_RST;
      stage_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (acrs_pkg::cfg_reg_e'(cfg_idx_i))
          acrs_pkg::REG_PRESENCE: presence_q <= cfg_data_i;
          acrs_pkg::REG_JUMP:     jump_q     <= cfg_data_i;
          acrs_pkg::REG_VALID_TH: valid_th_q <= cfg_data_i;
          acrs_pkg::REG_EDGE_TH:  edge_th_q  <= cfg_data_i;
          acrs_pkg::REG_INIT_ORDER: begin
            if (cfg_data_i[2:0] inside {[3'd1:3'd4]}) order_q <= cfg_data_i[2:0];
            else                                      order_q <= acrs_pkg::ORDER_DEFAULT;
          end
          default: ;
        endcase
      end
      if (accept) begin
        prev_q  <= prev_d;
        lastq_q <= lastq_d;
        vrun_q  <= vrun_d;
        irun_q  <= irun_d;
        order_q <= order_d;
      end
      if (adv_i) stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

  `ACRS_ASSERT_NOW(a_order_range, clk_i, rst_ni, 1'b1, order_q <= acrs_pkg::ORDER_MAX)
  `ACRS_ASSERT_NEXT(a_edge_resets_order, clk_i, rst_ni, accept && edge_hit, order_q == '0)
  `ACRS_ASSERT_NEXT(a_irun_saturates, clk_i, rst_ni,
                    accept && !valid && irun_q == acrs_pkg::IRUN_MAX,
                    irun_q == acrs_pkg::IRUN_MAX)

endmodule
`default_nettype wire

>>> design/acrs_cell.sv
// One smoothing cell: a 4-tap window, its sum, and the hand-off to the next cell.
`default_nettype none
module acrs_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire acrs_pkg::stage_t stage_i,
  output acrs_pkg::stage_t      stage_o
);

  `include "adaptive_cascade_range_smoother_assert.svh"

  acrs_pkg::win_t [acrs_pkg::TAPS-1:0] win_q, win_d;
  acrs_pkg::sum_t   sum;
  acrs_pkg::stage_t stage_q, stage_d;
  logic take;

  assign take = adv_i && stage_i.vld && stage_i.shift;

  // Window shift on a valid non-edge request
  always_comb begin
    win_d = win_q;
    if (stage_i.vld && stage_i.shift) begin
      win_d = {win_q[acrs_pkg::TAPS-2:0], stage_i.data};
    end
    sum = acrs_pkg::sum_t'(win_d[0]) + acrs_pkg::sum_t'(win_d[1]) +
          acrs_pkg::sum_t'(win_d[2]) + acrs_pkg::sum_t'(win_d[3]);
  end

  // Mean feeds the next cell; the selected cell drops its sum into the result
  always_comb begin
    stage_d      = stage_i;
    stage_d.data = sum[acrs_pkg::SUM_W-1:2];
    if (stage_i.hops == 3'd1) stage_d.result = acrs_pkg::res_t'(sum);
    if (stage_i.hops != '0)   stage_d.hops   = stage_i.hops - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      stage_q <= '0;
    end else begin
      if (take)  win_q   <= win_d;
      if (adv_i) stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

  `ACRS_ASSERT_NEXT(a_window_holds, clk_i, rst_ni, !take, $stable(win_q))

endmodule
`default_nettype wire
